@@ rtl/tehr_pkg.sv @@
// ---------------------------------------------------------------------------
// tehr_pkg - shared types and constants for the touch event to HID report block
// Event codes, report layout and slot table sizing.
// ---------------------------------------------------------------------------
package tehr_pkg;

	localparam int SLOT_COUNT = 10;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [15:0] TYPE_SYNC        = 16'd0;
	localparam logic [15:0] TYPE_ABS         = 16'd3;
	localparam logic [15:0] TYPE_DEVICE      = 16'd6;
	localparam logic [15:0] CODE_DEVICE_SET  = 16'h0001;
	localparam logic [15:0] CODE_SYNC_REPORT = 16'h0000;
	localparam logic [15:0] CODE_POS_X       = 16'h0035;
	localparam logic [15:0] CODE_POS_Y       = 16'h0036;
	localparam logic [15:0] CODE_SLOT        = 16'h002f;
	localparam logic [15:0] CODE_TRACK_ID    = 16'h0039;

	localparam logic [31:0] DEVICE_ACTIVE    = 32'd6;
	localparam logic [31:0] LIFTED_ID        = 32'hFFFF_FFFF;
	localparam logic [7:0]  KIND_MULTITOUCH  = 8'h04;
	localparam logic [7:0]  FLAG_IN_RANGE    = 8'h02;
	localparam logic [7:0]  FLAG_DATA_VALID  = 8'h04;

	typedef struct packed {
		logic [15:0] event_type;
		logic [15:0] event_code;
		logic [31:0] event_value;
	} event_t;

	typedef struct packed {
		logic [7:0]  report_kind;
		logic [7:0]  contact_flags;
		logic [15:0] touch_x;
		logic [15:0] touch_y;
	} report_t;

	// decoded event class
	typedef struct packed {
		logic dev_set;
		logic sync_rpt;
		logic pos_x;
		logic pos_y;
		logic slot_sel;
		logic track_id;
	} evt_class_t;

endpackage

@@ rtl/tehr_evt_if.sv @@
// ---------------------------------------------------------------------------
// tehr_evt_if - input event channel
// Valid/ready channel carrying one input event word.
// ---------------------------------------------------------------------------
interface tehr_evt_if;
	logic        valid;
	logic        ready;
	logic [15:0] event_type;
	logic [15:0] event_code;
	logic [31:0] event_value;

	modport source (output valid, output event_type, output event_code,
		output event_value, input ready);
	modport sink (input valid, input event_type, input event_code,
		input event_value, output ready);
endinterface

@@ rtl/tehr_rpt_if.sv @@
// ---------------------------------------------------------------------------
// tehr_rpt_if - output report channel
// Valid/ready channel carrying one multitouch report word.
// ---------------------------------------------------------------------------
interface tehr_rpt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  report_kind;
	logic [7:0]  contact_flags;
	logic [15:0] touch_x;
	logic [15:0] touch_y;

	modport source (output valid, output report_kind, output contact_flags,
		output touch_x, output touch_y, input ready);
	modport sink (input valid, input report_kind, input contact_flags,
		input touch_x, input touch_y, output ready);
endinterface

@@ rtl/tehr_decode.sv @@
// ---------------------------------------------------------------------------
// tehr_decode - event classifier
// Sorts a registered event word into the classes the slot table acts on.
// ---------------------------------------------------------------------------
module tehr_decode
	import tehr_pkg::*;
(
	input  event_t     evt,
	output evt_class_t cls
);

	logic is_abs;

	assign is_abs = (evt.event_type == TYPE_ABS);

	always_comb begin
		cls          = '0;
		cls.dev_set  = (evt.event_type == TYPE_DEVICE) && (evt.event_code == CODE_DEVICE_SET);
		cls.sync_rpt = (evt.event_type == TYPE_SYNC) && (evt.event_code == CODE_SYNC_REPORT);
		if (is_abs) begin
			unique case (evt.event_code)
				CODE_POS_X:    cls.pos_x    = 1'b1;
				CODE_POS_Y:    cls.pos_y    = 1'b1;
				CODE_SLOT:     cls.slot_sel = 1'b1;
				CODE_TRACK_ID: cls.track_id = 1'b1;
				default:       cls.pos_x    = 1'b0;
			endcase
		end
	end

endmodule

@@ rtl/tehr_slot_table.sv @@
// ---------------------------------------------------------------------------
// tehr_slot_table - per-slot contact state and report builder
// Holds X, Y and tip per slot plus the slot pointer and device select;
// applies one event per enabled cycle and builds the report it causes.
// ---------------------------------------------------------------------------
module tehr_slot_table
	import tehr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  evt_class_t cls,
	input  logic [31:0] value,
	output logic       emit,
	output report_t    rpt
);

	logic [15:0]       x_q   [SLOT_COUNT];
	logic [15:0]       y_q   [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] tip_q;
	logic [SLOT_W-1:0] cur_q;
	logic              jr_q;
	logic [31:0]       dev_q;

	logic [31:0] dev_nxt;
	logic        active;
	logic        slot_ok;
	logic [15:0] pos_val;
	logic [4:0]  slot_num;

	assign dev_nxt  = cls.dev_set ? value : dev_q;
	assign active   = (dev_nxt == DEVICE_ACTIVE);
	assign slot_ok  = (value < 32'(SLOT_COUNT));
	assign pos_val  = value[18:3];
	assign slot_num = 5'(cur_q);

	assign emit = active && (cls.sync_rpt || (cls.slot_sel && !jr_q));

	always_comb begin
		rpt.report_kind   = KIND_MULTITOUCH;
		rpt.contact_flags = {slot_num, 3'b000} | FLAG_IN_RANGE | FLAG_DATA_VALID
			| {7'd0, tip_q[cur_q]};
		rpt.touch_x       = x_q[cur_q];
		rpt.touch_y       = y_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				x_q[i] <= '0;
				y_q[i] <= '0;
			end
			tip_q <= '0;
			cur_q <= '0;
			jr_q  <= 1'b0;
			dev_q <= '0;
		end else if (en) begin
			dev_q <= dev_nxt;
			if (active) begin
				jr_q <= cls.sync_rpt;
				if (cls.pos_x)
					x_q[cur_q] <= pos_val;
				if (cls.pos_y)
					y_q[cur_q] <= pos_val;
				if (cls.track_id)
					tip_q[cur_q] <= (value != LIFTED_ID);
				if (cls.slot_sel && slot_ok)
					cur_q <= value[SLOT_W-1:0];
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < 32'(SLOT_COUNT))
		else $error("slot pointer out of range");

	a_jr_only_after_sync: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(jr_q) |-> $past(en && cls.sync_rpt))
		else $error("just-reported set without sync");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(dev_q != DEVICE_ACTIVE && !cls.dev_set) |-> !emit)
		else $error("report while device not selected");

endmodule

@@ rtl/tehr_out_buf.sv @@
// ---------------------------------------------------------------------------
// tehr_out_buf - two-word report buffer
// Decouples the report channel from the event pipeline; space is registered.
// ---------------------------------------------------------------------------
module tehr_out_buf
	import tehr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  report_t     din,
	output logic        space,
	tehr_rpt_if.source  rpt
);

	report_t    buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	report_t    head;

	assign pop   = rpt.valid && rpt.ready;
	assign space = (cnt_q != 2'd2);
	assign head  = buf_q[rd_q];

	assign rpt.valid         = (cnt_q != 2'd0);
	assign rpt.report_kind   = head.report_kind;
	assign rpt.contact_flags = head.contact_flags;
	assign rpt.touch_x       = head.touch_x;
	assign rpt.touch_y       = head.touch_y;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("push into full report buffer");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("report buffer count corrupt");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
		else $error("report buffer pointers disagree with count");

endmodule

@@ rtl/touch_event_to_hid_report_top.sv @@
// ---------------------------------------------------------------------------
// touch_event_to_hid_report_top - input events to multitouch HID reports
//
// Channels: evt (sink) takes one event word per handshake: type, code,
// value. rpt (source) gives one 6-byte report word: kind, flags, X, Y.
// Each event word yields zero or one report word.
// Flow: an event is registered on acceptance, then applied to the slot
// table once the output buffer has space; its report is written into a
// two-word output buffer and presented on rpt from there.
// Throughput: one event per cycle while the output buffer has space,
// set by the single slot table update.
// evt.ready depends only on registered state: it drops when the event
// register is full and the output buffer holds two words, so a stalled
// receiver holds back events without losing or repeating any report.
// Reset: all slots, the slot pointer, the just-reported flag and the
// selected device clear to zero; the buffers empty.
// ---------------------------------------------------------------------------
module touch_event_to_hid_report_top
	import tehr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tehr_evt_if.sink   evt,
	tehr_rpt_if.source rpt
);

	event_t     evt_s1;
	logic       vld_s1;
	logic       space;
	logic       adv;
	logic       emit;
	evt_class_t cls;
	report_t    rpt_w;

	assign adv       = vld_s1 && space;
	assign evt.ready = !vld_s1 || space;

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.event_type  <= evt.event_type;
			evt_s1.event_code  <= evt.event_code;
			evt_s1.event_value <= evt.event_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (evt.ready)
			vld_s1 <= evt.valid;
	end

	tehr_decode u_decode (
		.evt (evt_s1),
		.cls (cls)
	);

	tehr_slot_table u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cls    (cls),
		.value  (evt_s1.event_value),
		.emit   (emit),
		.rpt    (rpt_w)
	);

	tehr_out_buf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv && emit),
		.din    (rpt_w),
		.space  (space),
		.rpt    (rpt)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(evt_s1)))
		else $error("stalled event word lost");

	a_ready_reg: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (vld_s1 && !space))
		else $error("ready low without back-pressure");

	a_kind_const: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid |-> (rpt.report_kind == KIND_MULTITOUCH))
		else $error("bad report kind");

endmodule

@@ tb/touch_event_to_hid_report_top_tb.sv @@
// ---------------------------------------------------------------------------
// touch_event_to_hid_report_top_tb - self-checking bench for the report builder
// Drives input event words through the valid/ready event channel and checks
// every multitouch report word against a cycle-free predictor of the slot
// table. It covers a directed part, random gesture frames with noise, device
// deselection and random idling on both channels.
// ---------------------------------------------------------------------------
module touch_event_to_hid_report_top_tb;
	import tehr_pkg::*;

	localparam logic [7:0]  FLAG_TIP        = 8'h01;
	localparam logic [7:0]  SLOT_FIELD_MASK = 8'hF8;
	localparam logic [31:0] DEVICE_OTHER    = 32'd7;
	localparam int          GAP_MAX         = 15;
	localparam int          RUN_LIMIT       = 2_000_000;

	logic clk;
	logic arst_n;

	tehr_evt_if evt_ch ();
	tehr_rpt_if rpt_ch ();

	touch_event_to_hid_report_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.rpt    (rpt_ch)
	);

	// predicted state of the slot table
	logic [15:0] pos_x_tab [SLOT_COUNT];
	logic [15:0] pos_y_tab [SLOT_COUNT];
	logic        tip_tab   [SLOT_COUNT];
	int unsigned cur_slot;
	bit          sync_seen;
	logic [31:0] device_sel;

	report_t pending_reports [$];
	int      tx_max;
	int      rx_max;
	int      error_count;
	int      events_sent;
	int      handled_count;
	int      reports_checked;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("%0t: timeout, %0d reports still awaited", $time, pending_reports.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic report_t build_report(input int unsigned s);
		report_t rep;
		rep.report_kind   = KIND_MULTITOUCH;
		rep.contact_flags = (8'(s << 3) & SLOT_FIELD_MASK) | FLAG_IN_RANGE | FLAG_DATA_VALID |
			(tip_tab[s] ? FLAG_TIP : 8'h00);
		rep.touch_x       = pos_x_tab[s];
		rep.touch_y       = pos_y_tab[s];
		return rep;
	endfunction

	// updates the predicted table; returns 1 when the event yields a report
	function automatic bit apply_event(input event_t ev, output report_t rep);
		bit          emit;
		int unsigned s;
		emit = 1'b0;
		rep  = '0;
		s    = cur_slot;
		if (ev.event_type == TYPE_DEVICE && ev.event_code == CODE_DEVICE_SET)
			device_sel = ev.event_value;
		if (device_sel != DEVICE_ACTIVE)
			return 1'b0;
		if (ev.event_type == TYPE_SYNC && ev.event_code == CODE_SYNC_REPORT) begin
			rep       = build_report(s);
			sync_seen = 1'b1;
			return 1'b1;
		end
		if (ev.event_type == TYPE_ABS) begin
			case (ev.event_code)
				CODE_POS_X: begin
					pos_x_tab[s] = ev.event_value[18:3];
				end
				CODE_POS_Y: begin
					pos_y_tab[s] = ev.event_value[18:3];
				end
				CODE_SLOT: begin
					if (!sync_seen) begin
						rep  = build_report(s);
						emit = 1'b1;
					end
					if (ev.event_value < SLOT_COUNT)
						cur_slot = ev.event_value;
				end
				CODE_TRACK_ID: begin
					tip_tab[s] = (ev.event_value != LIFTED_ID);
				end
				default: ;
			endcase
		end
		sync_seen = 1'b0;
		return emit;
	endfunction

	task automatic send_event(input logic [15:0] ev_type, input logic [15:0] ev_code,
		input logic [31:0] ev_value);
		int      gap;
		event_t  ev;
		report_t rep;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid       <= 1'b1;
		evt_ch.event_type  <= ev_type;
		evt_ch.event_code  <= ev_code;
		evt_ch.event_value <= ev_value;
		do @(posedge clk); while (!evt_ch.ready);
		ev.event_type  = ev_type;
		ev.event_code  = ev_code;
		ev.event_value = ev_value;
		if (apply_event(ev, rep))
			pending_reports.push_back(rep);
		events_sent++;
		if (device_sel == DEVICE_ACTIVE)
			handled_count++;
	endtask

	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_slot();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, SLOT_COUNT - 1);
		else if (r < 93)
			return SLOT_COUNT + $urandom_range(0, 5);
		return $urandom();
	endfunction

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_event(16'($urandom()), 16'($urandom()), $urandom());
			1: send_event(TYPE_ABS, 16'($urandom()), $urandom());
			2: send_event(TYPE_SYNC, 16'($urandom_range(1, 65535)), $urandom());
			default: send_event(TYPE_DEVICE, $urandom_range(0, 1) ? CODE_DEVICE_SET :
				16'($urandom()), DEVICE_ACTIVE);
		endcase
	endtask

	task automatic send_gesture();
		int          kind;
		int          n;
		logic [31:0] v;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				send_event(TYPE_ABS, CODE_SLOT, pick_slot());
				if ($urandom_range(0, 2) == 0)
					send_event(TYPE_ABS, CODE_TRACK_ID,
						$urandom_range(0, 1) ? LIFTED_ID : $urandom());
				if ($urandom_range(0, 4) != 0)
					send_event(TYPE_ABS, CODE_POS_X, $urandom());
				if ($urandom_range(0, 4) != 0)
					send_event(TYPE_ABS, CODE_POS_Y, $urandom());
				if ($urandom_range(0, 9) == 0)
					send_noise();
			end
			send_event(TYPE_SYNC, CODE_SYNC_REPORT, $urandom_range(0, 1) ? 32'd0 : $urandom());
		end else if (kind < 88) begin
			send_noise();
		end else if (kind < 94) begin
			// deselect, a few ignored words, then back to the touch device
			v = $urandom();
			if (v == DEVICE_ACTIVE)
				v = DEVICE_OTHER;
			send_event(TYPE_DEVICE, CODE_DEVICE_SET, v);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1))
					send_event(TYPE_ABS, CODE_SLOT, pick_slot());
				else
					send_event(TYPE_SYNC, CODE_SYNC_REPORT, $urandom());
			end
			send_event(TYPE_DEVICE, CODE_DEVICE_SET, DEVICE_ACTIVE);
		end else begin
			// repeated syncs and slot changes straight after a sync
			repeat ($urandom_range(1, 3))
				send_event(TYPE_SYNC, CODE_SYNC_REPORT, $urandom());
			send_event(TYPE_ABS, CODE_SLOT, pick_slot());
			send_event(TYPE_ABS, CODE_SLOT, pick_slot());
		end
	endtask

	task automatic test_directed();
		send_event(TYPE_ABS, CODE_POS_X, $urandom());
		send_event(TYPE_SYNC, CODE_SYNC_REPORT, 32'd0);
		send_event(TYPE_DEVICE, CODE_DEVICE_SET, DEVICE_ACTIVE);
		send_event(TYPE_SYNC, CODE_SYNC_REPORT, 32'd0);
		send_event(TYPE_ABS, CODE_SLOT, 32'd3);
		send_event(TYPE_ABS, CODE_TRACK_ID, 32'd0);
		send_event(TYPE_ABS, CODE_POS_X, 32'hFFFF_FFFF);
		send_event(TYPE_ABS, CODE_POS_Y, 32'h0000_0007);
		send_event(TYPE_ABS, CODE_SLOT, SLOT_COUNT - 1);
		send_event(TYPE_ABS, CODE_POS_Y, 32'h0007_FFF8);
		send_event(TYPE_ABS, CODE_TRACK_ID, LIFTED_ID);
		send_event(TYPE_ABS, CODE_SLOT, SLOT_COUNT);
		send_event(TYPE_ABS, CODE_SLOT, 32'hFFFF_FFFF);
		send_event(TYPE_SYNC, CODE_SYNC_REPORT, 32'hFFFF_FFFF);
		send_event(16'hFFFF, CODE_POS_X, 32'h0000_1000);
		send_event(TYPE_ABS, CODE_SLOT, 32'd0);
		send_event(TYPE_ABS, 16'hFFFF, 32'h5555_AAAA);
		send_event(TYPE_SYNC, CODE_DEVICE_SET, 32'd0);
		send_event(TYPE_SYNC, CODE_SYNC_REPORT, 32'd0);
		send_event(TYPE_DEVICE, CODE_DEVICE_SET, DEVICE_ACTIVE);
		send_event(TYPE_ABS, CODE_SLOT, 32'd1);
		send_event(TYPE_DEVICE, CODE_DEVICE_SET, DEVICE_OTHER);
		send_event(TYPE_SYNC, CODE_SYNC_REPORT, 32'd0);
		send_event(TYPE_ABS, CODE_SLOT, 32'd2);
		send_event(TYPE_DEVICE, CODE_DEVICE_SET, DEVICE_ACTIVE);
	endtask

	task automatic test_gestures(input int n);
		int target;
		target = handled_count + n;
		while (handled_count < target) begin
			if ($urandom_range(0, 15) == 0) begin
				tx_max = $urandom_range(0, 1) ? GAP_MAX : 0;
				rx_max = $urandom_range(0, 1) ? GAP_MAX : 0;
			end
			send_gesture();
		end
	endtask

	task automatic test_sender_hold();
		repeat (3) send_gesture();
		wait_drained();
		repeat (3) send_gesture();
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin : chk_reports
		report_t exp_rep;
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			if (pending_reports.size() == 0) begin
				error_count++;
				$display("%0t: unexpected report, expected none, got %h %h %h %h", $time,
					rpt_ch.report_kind, rpt_ch.contact_flags, rpt_ch.touch_x, rpt_ch.touch_y);
			end else begin
				exp_rep = pending_reports.pop_front();
				check_field("report_kind", 16'(exp_rep.report_kind),
					16'(rpt_ch.report_kind));
				check_field("contact_flags", 16'(exp_rep.contact_flags),
					16'(rpt_ch.contact_flags));
				check_field("touch_x", exp_rep.touch_x, rpt_ch.touch_x);
				check_field("touch_y", exp_rep.touch_y, rpt_ch.touch_y);
				reports_checked++;
			end
		end
	end

	initial begin : report_sink
		int stall;
		rpt_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = $urandom_range(0, rx_max);
			if (stall > 0) begin
				rpt_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rpt_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rpt_ch.valid && rpt_ch.ready));
		end
	end

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			pos_x_tab[i] = '0;
			pos_y_tab[i] = '0;
			tip_tab[i]   = 1'b0;
		end
		cur_slot        = 0;
		sync_seen       = 1'b0;
		device_sel      = '0;
		tx_max          = GAP_MAX;
		rx_max          = GAP_MAX;
		error_count     = 0;
		events_sent     = 0;
		handled_count   = 0;
		reports_checked = 0;

		arst_n             <= 1'b0;
		evt_ch.valid       <= 1'b0;
		evt_ch.event_type  <= '0;
		evt_ch.event_code  <= '0;
		evt_ch.event_value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_gestures(600);
		test_sender_hold();
		test_gestures(650);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d event words (%0d while the touch device was selected).",
			events_sent, handled_count);
		$display("Checked %0d report words across slot, sync, noise and deselect traffic.",
			reports_checked);
		if (error_count == 0 && pending_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ touch_event_to_hid_report_top.f @@
rtl/tehr_pkg.sv
rtl/tehr_evt_if.sv
rtl/tehr_rpt_if.sv
rtl/tehr_decode.sv
rtl/tehr_slot_table.sv
rtl/tehr_out_buf.sv
rtl/touch_event_to_hid_report_top.sv
tb/touch_event_to_hid_report_top_tb.sv
